FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PLBE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define PLBE_NEVER(lbl, expr, msg) \
    `PLBE_ASSERT(lbl, !(expr), msg)

`endif

FILE: rtl/core/plbe_pkg.sv
// ----------------------------------------------------------------------------
// PackBits line encoder package
// Shared types, constants and run classification functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plbe_pkg;

    localparam int PIXEL_BITS  = 8;
    localparam int DATA_BITS   = 8;
    localparam int LEN_BITS    = 16;
    localparam int MAX_RUN     = 128;
    localparam int CNT_BITS    = $clog2(MAX_RUN + 1);
    localparam int WIN_DEPTH   = 3;
    localparam int FILL_BITS   = $clog2(WIN_DEPTH + 1);
    localparam int IQ_DEPTH    = 4;
    localparam int IQ_PTR_BITS = $clog2(IQ_DEPTH);
    localparam int IQ_CNT_BITS = $clog2(IQ_DEPTH + 1);
    localparam int OB_DEPTH    = 2;
    localparam int OB_PTR_BITS = $clog2(OB_DEPTH);
    localparam int OB_CNT_BITS = $clog2(OB_DEPTH + 1);

    typedef logic [PIXEL_BITS-1:0]  pixel_t;
    typedef logic [DATA_BITS-1:0]   data_t;
    typedef logic [LEN_BITS-1:0]    len_t;
    typedef logic [CNT_BITS-1:0]    cnt_t;
    typedef logic [FILL_BITS-1:0]   fill_t;
    typedef logic [1:0]             phase_t;
    typedef logic [2:0]             nemit_t;
    typedef logic [IQ_PTR_BITS-1:0] iq_ptr_t;
    typedef logic [IQ_CNT_BITS-1:0] iq_cnt_t;
    typedef logic [OB_PTR_BITS-1:0] ob_ptr_t;
    typedef logic [OB_CNT_BITS-1:0] ob_cnt_t;

    localparam len_t LEN_RESET = '1;
    localparam cnt_t RUN_MAX   = cnt_t'(MAX_RUN);

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_REP  = 2'd1,
        KIND_LIT  = 2'd2
    } run_kind_t;

    // One step of the run encoder, chosen from the current state.
    typedef enum logic [3:0] {
        ACT_BREAK,        // wait for the next pixel
        ACT_NONE_SINGLE,  // lone pixel at block end: value, code 0
        ACT_NONE_START,   // open a repeat or literal run
        ACT_REP_CLOSE,    // repeat code, value
        ACT_REP_INC,      // extend repeat run
        ACT_LIT_CLOSE,    // last literal value, literal code
        ACT_LIT_NEW,      // send held value, hold the new pixel
        ACT_LIT_SWITCH,   // literal code, held pixel starts a repeat run
        ACT_LIT_CLOSE3,   // absorb trailing pair and close
        ACT_LIT_TAKE3     // absorb isolated pair and keep going
    } action_t;

    typedef struct packed {
        pixel_t pixel;
        logic   ended;
    } pix_item_t;

    typedef struct packed {
        logic  is_code;
        data_t data;
        logic  block_done;
    } res_item_t;

    typedef struct packed {
        pixel_t [WIN_DEPTH-1:0] win;
        fill_t                  fill;
        run_kind_t              kind;
        pixel_t                 val;
        cnt_t                   cnt;
    } enc_state_t;

    function automatic action_t classify(enc_state_t s, logic ended);
        action_t a;
        a = ACT_BREAK;
        case (s.kind)
            KIND_NONE:
            begin
                if (s.fill == fill_t'(0))
                    a = ACT_BREAK;
                else if (s.fill == fill_t'(1))
                    a = ended ? ACT_NONE_SINGLE : ACT_BREAK;
                else
                    a = ACT_NONE_START;
            end
            KIND_REP:
            begin
                if ((s.cnt >= RUN_MAX) || ((s.fill == fill_t'(0)) && ended) ||
                    ((s.fill != fill_t'(0)) && (s.win[0] != s.val)))
                    a = ACT_REP_CLOSE;
                else if (s.fill == fill_t'(0))
                    a = ACT_BREAK;
                else
                    a = ACT_REP_INC;
            end
            KIND_LIT:
            begin
                if ((s.cnt >= RUN_MAX) || ((s.fill == fill_t'(0)) && ended))
                    a = ACT_LIT_CLOSE;
                else if (s.fill == fill_t'(0))
                    a = ACT_BREAK;
                else if (s.win[0] != s.val)
                    a = ACT_LIT_NEW;
                else if ((s.cnt + cnt_t'(1)) >= RUN_MAX)
                    a = ACT_LIT_SWITCH;
                else if (s.fill >= fill_t'(2))
                begin
                    if (s.win[1] == s.win[0])
                        a = ACT_LIT_SWITCH;
                    else if ((s.cnt + cnt_t'(2)) == RUN_MAX)
                        a = ACT_LIT_CLOSE3;
                    else if (s.fill == fill_t'(3))
                        a = (s.win[1] != s.win[2]) ? ACT_LIT_TAKE3 : ACT_LIT_SWITCH;
                    else if (ended)
                        a = ACT_LIT_CLOSE3;
                    else
                        a = ACT_BREAK;
                end
                else if (ended)
                    a = ACT_LIT_SWITCH;
                else
                    a = ACT_BREAK;
            end
            default:
                a = ACT_BREAK;
        endcase
        return a;
    endfunction

    function automatic nemit_t emit_count(action_t a);
        nemit_t n;
        case (a)
            ACT_NONE_SINGLE: n = nemit_t'(2);
            ACT_REP_CLOSE:   n = nemit_t'(2);
            ACT_LIT_CLOSE:   n = nemit_t'(2);
            ACT_LIT_NEW:     n = nemit_t'(1);
            ACT_LIT_SWITCH:  n = nemit_t'(1);
            ACT_LIT_CLOSE3:  n = nemit_t'(4);
            ACT_LIT_TAKE3:   n = nemit_t'(3);
            default:         n = nemit_t'(0);
        endcase
        return n;
    endfunction

    function automatic enc_state_t pop_win(enc_state_t s, fill_t k);
        enc_state_t r;
        r = s;
        for (int j = 0; j < WIN_DEPTH; j++)
        begin
            if ((j < int'(k)) && (r.fill != fill_t'(0)))
            begin
                r.win  = {pixel_t'(0), r.win[WIN_DEPTH-1:1]};
                r.fill = r.fill - fill_t'(1);
            end
        end
        return r;
    endfunction

    function automatic enc_state_t append(enc_state_t s, pixel_t px);
        enc_state_t r;
        r = s;
        if (s.fill == fill_t'(WIN_DEPTH))
            r.win[WIN_DEPTH-1] = px;
        else
        begin
            r.win[s.fill[1:0]] = px;
            r.fill = s.fill + fill_t'(1);
        end
        return r;
    endfunction

    function automatic enc_state_t execute(enc_state_t s, action_t a);
        enc_state_t r;
        r = s;
        case (a)
            ACT_NONE_SINGLE:
                r = pop_win(s, fill_t'(1));
            ACT_NONE_START:
            begin
                r.kind = (s.win[0] == s.win[1]) ? KIND_REP : KIND_LIT;
                r.val  = s.win[0];
                r.cnt  = cnt_t'(1);
                r = pop_win(r, fill_t'(1));
            end
            ACT_REP_CLOSE, ACT_LIT_CLOSE:
            begin
                r.kind = KIND_NONE;
                r.cnt  = '0;
            end
            ACT_REP_INC:
            begin
                r.cnt = s.cnt + cnt_t'(1);
                r = pop_win(r, fill_t'(1));
            end
            ACT_LIT_NEW:
            begin
                r.val = s.win[0];
                r.cnt = s.cnt + cnt_t'(1);
                r = pop_win(r, fill_t'(1));
            end
            ACT_LIT_SWITCH:
            begin
                r.kind = KIND_REP;
                r.cnt  = cnt_t'(1);
            end
            ACT_LIT_CLOSE3:
            begin
                r.kind = KIND_NONE;
                r.cnt  = '0;
                r = pop_win(r, fill_t'(2));
            end
            ACT_LIT_TAKE3:
            begin
                r.val = s.win[2];
                r.cnt = s.cnt + cnt_t'(3);
                r = pop_win(r, fill_t'(3));
            end
            default:
                r = s;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/plbe_in_if.sv
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one pixel and its line end mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface plbe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       line_end;

    modport source (output valid, output pixel, output line_end, input ready);
    modport sink   (input valid, input pixel, input line_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/plbe_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one code or value byte of the encoded stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface plbe_out_if;
    logic       valid;
    logic       ready;
    logic       is_code;
    logic [7:0] data;
    logic       block_done;

    modport source (output valid, output is_code, output data, output block_done,
                    input ready);
    modport sink   (input valid, input is_code, input data, input block_done,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/plbe_front.sv
// ----------------------------------------------------------------------------
// Encoder front end
// Accepts pixels, tracks the block position, tags block ends, queues items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module plbe_front (
    input  logic                clk,
    input  logic                rst_n,
    plbe_in_if.sink             pixels,
    input  logic                cfg_we,
    input  plbe_pkg::len_t      cfg_wdata,
    input  logic                q_pop,
    output logic                q_valid,
    output plbe_pkg::pix_item_t q_item
);

    plbe_pkg::len_t              len_reg;
    plbe_pkg::len_t              pos_reg;
    plbe_pkg::len_t              pos_next;
    logic [plbe_pkg::LEN_BITS:0] lim;
    logic [plbe_pkg::LEN_BITS:0] pos_p1;
    logic                        ended;
    logic                        push;
    plbe_pkg::pix_item_t         in_item;

    plbe_pkg::pix_item_t         iq_mem_reg [plbe_pkg::IQ_DEPTH];
    plbe_pkg::iq_ptr_t           iq_wr_ptr_reg;
    plbe_pkg::iq_ptr_t           iq_rd_ptr_reg;
    plbe_pkg::iq_cnt_t           iq_cnt_reg;
    plbe_pkg::iq_cnt_t           iq_cnt_next;

    // length 0 means 65536
    assign lim    = (len_reg == '0) ? {1'b1, {plbe_pkg::LEN_BITS{1'b0}}} : {1'b0, len_reg};
    assign pos_p1 = {1'b0, pos_reg} + (plbe_pkg::LEN_BITS + 1)'(1);
    assign ended  = pixels.line_end || (pos_p1 >= lim);

    assign pos_next = ended ? '0 : pos_p1[plbe_pkg::LEN_BITS-1:0];

    assign in_item.pixel = plbe_pkg::pixel_t'(pixels.pixel);
    assign in_item.ended = ended;

    assign pixels.ready = (iq_cnt_reg != plbe_pkg::iq_cnt_t'(plbe_pkg::IQ_DEPTH));
    assign push         = pixels.valid && pixels.ready;

    assign q_valid = (iq_cnt_reg != '0);
    assign q_item  = iq_mem_reg[iq_rd_ptr_reg];

    always_comb
    begin
        iq_cnt_next = iq_cnt_reg;
        case ({push, q_pop})
            2'b10:   iq_cnt_next = iq_cnt_reg + plbe_pkg::iq_cnt_t'(1);
            2'b01:   iq_cnt_next = iq_cnt_reg - plbe_pkg::iq_cnt_t'(1);
            default: iq_cnt_next = iq_cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= plbe_pkg::LEN_RESET;
            pos_reg       <= '0;
            iq_wr_ptr_reg <= '0;
            iq_rd_ptr_reg <= '0;
            iq_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                len_reg <= cfg_wdata;
            if (push)
            begin
                pos_reg       <= pos_next;
                iq_wr_ptr_reg <= iq_wr_ptr_reg + plbe_pkg::iq_ptr_t'(1);
            end
            if (q_pop)
                iq_rd_ptr_reg <= iq_rd_ptr_reg + plbe_pkg::iq_ptr_t'(1);
            iq_cnt_reg <= iq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            iq_mem_reg[iq_wr_ptr_reg] <= in_item;
    end

    `PLBE_ASSERT(a_pos_restart, (push && ended) |=> (pos_reg == '0), "block position not restarted")
    `PLBE_NEVER(a_iq_pop_empty, q_pop && (iq_cnt_reg == '0), "pop from empty pixel queue")

endmodule

`default_nettype wire

FILE: rtl/core/plbe_back.sv
// ----------------------------------------------------------------------------
// Encoder back end
// Run sequencer: one encoder step per cycle unless the result buffer is full, at most one result per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module plbe_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  plbe_pkg::pix_item_t q_item,
    output logic                q_pop,
    input  logic                ob_full,
    output logic                ob_wr,
    output plbe_pkg::res_item_t ob_data
);

    plbe_pkg::enc_state_t st_reg;
    plbe_pkg::enc_state_t st_next;
    plbe_pkg::enc_state_t st_app;
    plbe_pkg::enc_state_t st_eff;
    logic                 ended_reg;
    logic                 ended_next;
    logic                 ended_eff;
    plbe_pkg::phase_t     phase_reg;
    plbe_pkg::phase_t     phase_next;
    plbe_pkg::res_item_t  hold_reg;
    plbe_pkg::res_item_t  hold_next;
    logic                 hold_vld_reg;
    logic                 hold_vld_next;

    plbe_pkg::action_t    act_r;
    plbe_pkg::action_t    act;
    logic                 brk_r;
    logic                 flush;
    logic                 load;
    plbe_pkg::nemit_t     n_emit;
    logic                 emit;
    logic                 last;
    logic                 want_wr;
    logic                 go;
    plbe_pkg::res_item_t  res_new;
    plbe_pkg::cnt_t       cm1;
    plbe_pkg::cnt_t       cm2;
    plbe_pkg::cnt_t       cp1;

    // At a wait point the next pixel is appended and stepped in the same cycle.
    always_comb
    begin
        act_r     = plbe_pkg::classify(st_reg, ended_reg);
        brk_r     = (act_r == plbe_pkg::ACT_BREAK);
        flush     = brk_r && ended_reg;
        load      = brk_r && !ended_reg && q_valid;
        st_app    = plbe_pkg::append(st_reg, q_item.pixel);
        st_eff    = load ? st_app : st_reg;
        ended_eff = load ? q_item.ended : ended_reg;
        act       = load ? plbe_pkg::classify(st_app, q_item.ended) : act_r;
        n_emit    = plbe_pkg::emit_count(act);
        emit      = (n_emit != '0);
        last      = !emit || ({1'b0, phase_reg} == (n_emit - plbe_pkg::nemit_t'(1)));
    end

    // Result byte for the current action and phase
    always_comb
    begin
        cm1 = st_eff.cnt - plbe_pkg::cnt_t'(1);
        cm2 = st_eff.cnt - plbe_pkg::cnt_t'(2);
        cp1 = st_eff.cnt + plbe_pkg::cnt_t'(1);
        res_new.is_code    = 1'b0;
        res_new.data       = plbe_pkg::data_t'(st_eff.val);
        res_new.block_done = 1'b0;
        case (act)
            plbe_pkg::ACT_NONE_SINGLE:
            begin
                if (phase_reg == plbe_pkg::phase_t'(0))
                    res_new.data = plbe_pkg::data_t'(st_eff.win[0]);
                else
                begin
                    res_new.is_code = 1'b1;
                    res_new.data    = '0;
                end
            end
            plbe_pkg::ACT_REP_CLOSE:
            begin
                if (phase_reg == plbe_pkg::phase_t'(0))
                begin
                    res_new.is_code = 1'b1;
                    res_new.data    = plbe_pkg::data_t'({cm1, 1'b1});
                end
            end
            plbe_pkg::ACT_LIT_CLOSE:
            begin
                if (phase_reg != plbe_pkg::phase_t'(0))
                begin
                    res_new.is_code = 1'b1;
                    res_new.data    = plbe_pkg::data_t'({cm1, 1'b0});
                end
            end
            plbe_pkg::ACT_LIT_SWITCH:
            begin
                res_new.is_code = 1'b1;
                res_new.data    = plbe_pkg::data_t'({cm2, 1'b0});
            end
            plbe_pkg::ACT_LIT_CLOSE3, plbe_pkg::ACT_LIT_TAKE3:
            begin
                case (phase_reg)
                    plbe_pkg::phase_t'(1):
                        res_new.data = plbe_pkg::data_t'(st_eff.win[0]);
                    plbe_pkg::phase_t'(2):
                        res_new.data = plbe_pkg::data_t'(st_eff.win[1]);
                    plbe_pkg::phase_t'(3):
                    begin
                        res_new.is_code = 1'b1;
                        res_new.data    = plbe_pkg::data_t'({cp1, 1'b0});
                    end
                    default:
                        res_new.data = plbe_pkg::data_t'(st_eff.val);
                endcase
            end
            default:
                res_new.data = plbe_pkg::data_t'(st_eff.val);
        endcase
    end

    // Results of a block-ending pixel pass through the hold register so that
    // the final one can carry block_done.
    always_comb
    begin
        want_wr = 1'b0;
        ob_data = res_new;
        if (flush)
        begin
            want_wr            = hold_vld_reg;
            ob_data            = hold_reg;
            ob_data.block_done = 1'b1;
        end
        else if (emit && ended_eff)
        begin
            want_wr = hold_vld_reg;
            ob_data = hold_reg;
        end
        else if (emit)
            want_wr = 1'b1;
        go    = !want_wr || !ob_full;
        ob_wr = want_wr && !ob_full;
        q_pop = load && go;
    end

    always_comb
    begin
        st_next       = st_reg;
        ended_next    = ended_reg;
        phase_next    = phase_reg;
        hold_next     = hold_reg;
        hold_vld_next = hold_vld_reg;
        if (go)
        begin
            if (flush)
            begin
                st_next.fill  = '0;
                st_next.kind  = plbe_pkg::KIND_NONE;
                st_next.cnt   = '0;
                ended_next    = 1'b0;
                phase_next    = '0;
                hold_vld_next = 1'b0;
            end
            else
            begin
                ended_next = ended_eff;
                if (emit && !last)
                begin
                    st_next    = st_eff;
                    phase_next = phase_reg + plbe_pkg::phase_t'(1);
                end
                else
                begin
                    st_next    = plbe_pkg::execute(st_eff, act);
                    phase_next = '0;
                end
                if (emit && ended_eff)
                begin
                    hold_next     = res_new;
                    hold_vld_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= '0;
            ended_reg    <= 1'b0;
            phase_reg    <= '0;
            hold_vld_reg <= 1'b0;
        end
        else
        begin
            st_reg       <= st_next;
            ended_reg    <= ended_next;
            phase_reg    <= phase_next;
            hold_vld_reg <= hold_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    `PLBE_ASSERT(a_phase_mid_step, (phase_reg != '0) |-> !brk_r, "phase set at a wait point")
    `PLBE_ASSERT(a_hold_only_at_end, hold_vld_reg |-> ended_reg, "held result outside block end")
    `PLBE_ASSERT(a_idle_count, (st_reg.kind == plbe_pkg::KIND_NONE) |-> (st_reg.cnt == '0), "count left with no run open")
    `PLBE_ASSERT(a_flush_clears, (flush && go) |=> ((st_reg.fill == '0) && !ended_reg && !hold_vld_reg), "block end did not clear state")

endmodule

`default_nettype wire

FILE: rtl/core/plbe_obuf.sv
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry queue that decouples the sequencer from the result receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plbe_obuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr,
    input  plbe_pkg::res_item_t wdata,
    output logic                full,
    plbe_out_if.source          results
);

    plbe_pkg::res_item_t mem_reg [plbe_pkg::OB_DEPTH];
    plbe_pkg::ob_ptr_t   wr_ptr_reg;
    plbe_pkg::ob_ptr_t   rd_ptr_reg;
    plbe_pkg::ob_cnt_t   cnt_reg;
    plbe_pkg::ob_cnt_t   cnt_next;
    plbe_pkg::res_item_t head;
    logic                rd;

    assign full = (cnt_reg == plbe_pkg::ob_cnt_t'(plbe_pkg::OB_DEPTH));
    assign head = mem_reg[rd_ptr_reg];

    assign results.valid      = (cnt_reg != '0);
    assign results.is_code    = head.is_code;
    assign results.data       = head.data;
    assign results.block_done = head.block_done;
    assign rd                 = results.valid && results.ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({wr, rd})
            2'b10:   cnt_next = cnt_reg + plbe_pkg::ob_cnt_t'(1);
            2'b01:   cnt_next = cnt_reg - plbe_pkg::ob_cnt_t'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr)
                wr_ptr_reg <= wr_ptr_reg + plbe_pkg::ob_ptr_t'(1);
            if (rd)
                rd_ptr_reg <= rd_ptr_reg + plbe_pkg::ob_ptr_t'(1);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

FILE: rtl/core/packbits_line_encoder_top.sv
// ----------------------------------------------------------------------------
// PackBits line encoder
// Run-length encodes image lines block by block into codes and values.
// ----------------------------------------------------------------------------
// Usage:
//  - pixels: valid/ready channel, one pixel per transaction, line_end marks
//    the last pixel of a line.
//  - results: valid/ready channel, one byte per transaction; is_code tells a
//    length code from a pixel value, block_done flags the last byte of a block.
//  - cfg_we/cfg_wdata: block_length write, only while the encoder is idle.
//    Zero means 65536 pixels.
//  - Sequencer: one step per cycle while the result buffer has room, at most
//    one byte per step. A pixel that closes a run releases its bytes one per
//    step, opening a run takes a step of its own, and a block end releases
//    the held last byte, tagged block_done, in a step of its own.
//  - Path: a pixel passes the pixel queue and the sequencer into the result
//    buffer; bytes of a block-ending pixel also pass the hold register.
//  - Stall: when results is held off, the two-entry result buffer fills, the
//    sequencer waits, then the four-entry pixel queue fills and ready drops.
//  - Reset: clears queues and run state; block_length returns to 65535.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module packbits_line_encoder_top (
    input  logic           clk,
    input  logic           rst_n,
    plbe_in_if.sink        pixels,
    plbe_out_if.source     results,
    input  logic           cfg_we,
    input  plbe_pkg::len_t cfg_wdata
);

    // front end to sequencer
    logic                q_valid;
    logic                q_pop;
    plbe_pkg::pix_item_t q_item;

    // sequencer to result buffer
    logic                ob_full;
    logic                ob_wr;
    plbe_pkg::res_item_t ob_data;

    // Block position, block end tagging and pixel queue
    plbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixels    (pixels),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_pop     (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // Run sequencer: lookahead window, open run, result ordering
    plbe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .ob_full (ob_full),
        .ob_wr   (ob_wr),
        .ob_data (ob_data)
    );

    // Output skid buffer
    plbe_obuf u_obuf (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (ob_wr),
        .wdata   (ob_data),
        .full    (ob_full),
        .results (results)
    );

endmodule

`default_nettype wire
